FILE: sv/tlbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlbp_pkg: shared types and constants for the TLB probe/translate block
// Entry layout, field widths and item codes used by the store and top level.
// ----------------------------------------------------------------------------
package tlbp_pkg;

	localparam int ENTRIES = 32;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Field widths of the stored words (only the bits the translation uses)
	localparam int VPN2_W = 19;
	localparam int ASID_W = 8;
	localparam int MASK_W = 25;
	localparam int PFN_W  = 20;
	localparam int OFS_W  = MASK_W;

	// Item codes
	localparam logic OP_PROBE = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Result for an address that does not translate
	localparam logic [31:0] PADDR_NONE = 32'hFFFF_FFFF;

	// One page pair of the smallest size (0x2000) at the width of the mask sum
	localparam logic [MASK_W:0] PAGE_STEP = (MASK_W + 1)'(32'h2000);

	// One EntryLo word reduced to the PFN bits that land in 32 bits and valid
	typedef struct packed {
		logic [PFN_W-1:0] pfn;
		logic             valid;
	} tlbp_lo_t;

	typedef struct packed {
		logic [VPN2_W-1:0] vpn2;
		logic [ASID_W-1:0] asid;
		logic [MASK_W-1:0] mask;
		tlbp_lo_t          lo_even;
		tlbp_lo_t          lo_odd;
		logic              global_bit;
	} tlbp_entry_t;

endpackage
`default_nettype wire

FILE: sv/tlbp_entry_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlbp_entry_store: TLB entry register file
// One write port, one read port; an entry never written reads as all zeros.
// ----------------------------------------------------------------------------
module tlbp_entry_store (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [tlbp_pkg::IDX_W-1:0]  wr_idx,
	input  wire tlbp_pkg::tlbp_entry_t       wr_entry,
	input  wire logic [tlbp_pkg::IDX_W-1:0]  rd_idx,
	output tlbp_pkg::tlbp_entry_t            rd_entry
);

	tlbp_pkg::tlbp_entry_t                entry_q [tlbp_pkg::ENTRIES];
	logic [tlbp_pkg::ENTRIES-1:0]         entry_vld_q;

	// Valid bits stand in for clearing the payload at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
		end else if (wr_en) begin
			entry_vld_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_idx] <= wr_entry;
		end
	end

	always_comb begin
		if (entry_vld_q[rd_idx]) begin
			rd_entry = entry_q[rd_idx];
		end else begin
			rd_entry = '0;
		end
	end

endmodule
`default_nettype wire

FILE: sv/tlb_probe_translate_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_probe_translate_top: 32-entry MIPS-style TLB with probe and translate
//
// Input channel (in_valid / in_stall) carries one transaction per item: op
// selects a probe of virt_addr or a write of one entry (entry_* fields).
// A write is stored at the accepting edge and returns nothing; writes to an
// index beyond the store are dropped. A probe returns one transaction on
// the output channel (out_valid / out_stall): matched, translated and
// phys_addr (all ones when the address does not translate).
// A probe walks the entries one per cycle through a single VPN2/ASID
// comparator and stops at the first hit, then picks the page (ST_SEL),
// masks the offset (ST_OFS), adds the frame base (ST_ADDR) and loads the
// output register from ST_FIN. in_stall is high until the sequencer is
// back in ST_IDLE, so one probe is in flight at a time; a write does not
// leave ST_IDLE, so the next item is not held back by it.
// The output register holds its transaction while out_stall is high; the
// next item is accepted meanwhile, and its probe waits at the end of its
// walk until the register frees up. Reset makes every entry read as zero
// and clears current_asid and out_valid. The user writes current_asid with
// current_asid_we only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module tlb_probe_translate_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        current_asid_we,
	input  wire logic [7:0]  current_asid,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [4:0]  entry_index,
	input  wire logic [31:0] entry_hi,
	input  wire logic [24:0] entry_page_mask,
	input  wire logic [31:0] entry_lo_even,
	input  wire logic [31:0] entry_lo_odd,
	input  wire logic        entry_global,
	input  wire logic [31:0] virt_addr,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             matched,
	output logic             translated,
	output logic [31:0]      phys_addr
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_SEL  = 6'b000100,
		ST_OFS  = 6'b001000,
		ST_ADDR = 6'b010000,
		ST_FIN  = 6'b100000
	} tlbp_state_t;

	tlbp_state_t                         state_q;
	logic [tlbp_pkg::ASID_W-1:0]         asid_q;
	logic [tlbp_pkg::IDX_W-1:0]          scan_idx_q;
	logic [31:0]                         vaddr_q;
	tlbp_pkg::tlbp_entry_t               hit_q;
	logic [tlbp_pkg::MASK_W-1:0]         sel_q;
	tlbp_pkg::tlbp_lo_t                  page_q;
	logic [tlbp_pkg::OFS_W-1:0]          ofs_q;
	logic                                res_matched_q;
	logic                                res_translated_q;
	logic [31:0]                         res_paddr_q;
	logic                                out_valid_q;
	logic                                out_matched_q;
	logic                                out_translated_q;
	logic [31:0]                         out_paddr_q;

	logic                                in_accept;
	logic                                wr_en;
	tlbp_pkg::tlbp_entry_t               wr_entry;
	tlbp_pkg::tlbp_entry_t               rd_entry;
	logic                                hit;
	logic                                scan_last;
	logic [tlbp_pkg::MASK_W:0]           mask_sum;
	logic [tlbp_pkg::MASK_W-1:0]         sel;
	logic                                out_free;
	logic [31:0]                         paddr_sum;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// Write path: keep only the bits a translation can see
	assign wr_en = in_accept && (op == tlbp_pkg::OP_WRITE) &&
	               (32'(entry_index) < tlbp_pkg::ENTRIES);

	always_comb begin
		wr_entry.vpn2          = entry_hi[31:13];
		wr_entry.asid          = entry_hi[7:0];
		wr_entry.mask          = entry_page_mask;
		wr_entry.lo_even.pfn   = entry_lo_even[25:6];
		wr_entry.lo_even.valid = entry_lo_even[1];
		wr_entry.lo_odd.pfn    = entry_lo_odd[25:6];
		wr_entry.lo_odd.valid  = entry_lo_odd[1];
		wr_entry.global_bit    = entry_global;
	end

	tlbp_entry_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_idx   (tlbp_pkg::IDX_W'(entry_index)),
		.wr_entry (wr_entry),
		.rd_idx   (scan_idx_q),
		.rd_entry (rd_entry)
	);

	// Shared comparator: one entry per scan cycle
	assign hit = (rd_entry.vpn2 == vaddr_q[31:13]) &&
	             (rd_entry.global_bit || (rd_entry.asid == asid_q));
	assign scan_last = (scan_idx_q == tlbp_pkg::IDX_W'(tlbp_pkg::ENTRIES - 1));

	// Page-select bit: (mask + 0x2000) >> 1
	assign mask_sum = {1'b0, hit_q.mask} + tlbp_pkg::PAGE_STEP;
	assign sel      = mask_sum[tlbp_pkg::MASK_W:1];

	assign paddr_sum = {page_q.pfn, 12'h000} + 32'(ofs_q);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asid_q <= '0;
		end else if (current_asid_we) begin
			asid_q <= current_asid;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					scan_idx_q <= '0;
					if (in_accept && (op == tlbp_pkg::OP_PROBE)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						state_q <= ST_SEL;
					end else if (scan_last) begin
						state_q <= ST_FIN;
					end else begin
						scan_idx_q <= scan_idx_q + tlbp_pkg::IDX_W'(1);
					end
				end
				ST_SEL:  state_q <= ST_OFS;
				ST_OFS:  state_q <= ST_ADDR;
				ST_ADDR: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			vaddr_q <= virt_addr;
		end
		if (state_q == ST_SCAN) begin
			hit_q <= rd_entry;
			if (!hit && scan_last) begin
				res_matched_q    <= 1'b0;
				res_translated_q <= 1'b0;
				res_paddr_q      <= tlbp_pkg::PADDR_NONE;
			end
		end
		if (state_q == ST_SEL) begin
			sel_q <= sel;
			// Address bit under sel picks the odd page
			if ((vaddr_q[tlbp_pkg::MASK_W-1:0] & sel) == '0) begin
				page_q <= hit_q.lo_even;
			end else begin
				page_q <= hit_q.lo_odd;
			end
		end
		if (state_q == ST_OFS) begin
			ofs_q <= vaddr_q[tlbp_pkg::OFS_W-1:0] & (sel_q - tlbp_pkg::MASK_W'(1));
		end
		if (state_q == ST_ADDR) begin
			res_matched_q    <= 1'b1;
			res_translated_q <= page_q.valid;
			res_paddr_q      <= page_q.valid ? paddr_sum : tlbp_pkg::PADDR_NONE;
		end
	end

	// Output register: hold while stalled, load when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_matched_q    <= res_matched_q;
			out_translated_q <= res_translated_q;
			out_paddr_q      <= res_paddr_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign matched    = out_matched_q;
	assign translated = out_translated_q;
	assign phys_addr  = out_paddr_q;

endmodule
`default_nettype wire
